### src/lcdw_pkg.sv
// Shared types and constants for the LCD decimal field writer.
package lcdw_pkg;

    localparam int ADDR_W      = 8;
    localparam int VALUE_W     = 16;
    localparam int COUNT_W     = 4;
    localparam int DIGIT_W     = 4;
    localparam int BYTE_W      = 8;
    localparam int PROD_W      = 32;
    localparam int RECIP_SHIFT = 19;

    localparam logic [VALUE_W-1:0] RECIP_TEN  = 16'd52429;
    localparam logic [BYTE_W-1:0]  ASCII_ZERO = 8'h30;

    typedef struct packed {
        logic load;
        logic conv;
        logic emit_cmd;
        logic emit_digit;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic slot_last;
    } t_dp_status;

endpackage

### src/lcdw_datapath.sv
// Datapath: digit extraction by reciprocal multiply, digit store and bus word register.
module lcdw_datapath
    import lcdw_pkg::*;
#(
    parameter int DIGIT_SLOTS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [ADDR_W-1:0]  i_ddram_address,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [COUNT_W-1:0] i_digit_count,
    output t_dp_status         o_status,
    output logic               o_strobe,
    output logic               o_is_data,
    output logic [BYTE_W-1:0]  o_bus_byte,
    output logic               o_last
);

    localparam int SLOT_W = $clog2(DIGIT_SLOTS);
    localparam logic [COUNT_W-1:0] SLOTS_C   = COUNT_W'(DIGIT_SLOTS);
    localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(DIGIT_SLOTS - 1);

    logic [ADDR_W-1:0]  r_addr;
    logic [VALUE_W-1:0] r_rest;
    logic               r_count_zero;
    logic [SLOT_W-1:0]  r_slot;
    logic [DIGIT_W-1:0] r_digit [DIGIT_SLOTS];
    logic               r_strobe;
    logic               r_is_data;
    logic [BYTE_W-1:0]  r_byte;
    logic               r_last;

    logic [COUNT_W-1:0] w_count_sat;
    logic [COUNT_W-1:0] w_start_full;
    logic [PROD_W-1:0]  w_prod;
    logic [VALUE_W-1:0] w_quot;
    logic [VALUE_W-1:0] w_quot10;
    logic [DIGIT_W-1:0] w_rem;
    logic               w_slot_last;

    always_comb begin
        w_count_sat  = (i_digit_count > SLOTS_C) ? SLOTS_C : i_digit_count;
        w_start_full = SLOTS_C - w_count_sat;
        w_prod       = PROD_W'(r_rest) * PROD_W'(RECIP_TEN);
        w_quot       = VALUE_W'(w_prod >> RECIP_SHIFT);
        w_quot10     = (w_quot << 3) + (w_quot << 1);
        w_rem        = DIGIT_W'(r_rest - w_quot10);
        w_slot_last  = (r_slot == SLOT_LAST);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr       <= i_ddram_address;
            r_rest       <= i_value;
            r_count_zero <= (w_count_sat == '0);
            r_slot       <= SLOT_W'(w_start_full);
        end
        if (i_cmd.conv) begin
            r_rest <= w_quot;
            for (int k = DIGIT_SLOTS - 1; k > 0; k--) begin
                r_digit[k] <= r_digit[k-1];
            end
            r_digit[0] <= w_rem;
        end
        if (i_cmd.emit_digit) begin
            r_slot <= r_slot + 1'b1;
        end
        r_is_data <= i_cmd.emit_digit;
        r_byte    <= i_cmd.emit_cmd ? r_addr
                                    : (ASCII_ZERO | BYTE_W'(r_digit[r_slot]));
        r_last    <= i_cmd.emit_cmd ? r_count_zero : w_slot_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit_cmd | i_cmd.emit_digit;
        end
    end

    assign o_status.count_zero = r_count_zero;
    assign o_status.slot_last  = w_slot_last;
    assign o_strobe            = r_strobe;
    assign o_is_data           = r_is_data;
    assign o_bus_byte          = r_byte;
    assign o_last              = r_last;

`ifndef SYNTHESIS
    a_digit_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_is_data) |-> (o_bus_byte[7:4] == 4'h3 && o_bus_byte[3:0] <= 4'd9))
        else $error("data word is not an ASCII digit");
`endif

endmodule

### src/lcdw_ctrl.sv
// Controller: sequences load, digit conversion and bus word emission.
module lcdw_ctrl
    import lcdw_pkg::*;
#(
    parameter int DIGIT_SLOTS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output logic       o_busy,
    output t_dp_cmd    o_cmd
);

    localparam int STEP_W = $clog2(DIGIT_SLOTS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIGIT_SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.conv     = 1'b1;
                o_cmd.emit_cmd = (r_step == '0);
                n_step         = r_step + 1'b1;
                priority if (r_step == '0 && i_status.count_zero) begin
                    n_state = S_IDLE;
                end else if (r_step == STEP_LAST) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit_digit = 1'b1;
                if (i_status.slot_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_accept_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> (r_state == S_CONV && o_cmd.emit_cmd))
        else $error("command word not issued after accept");
    a_emit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && i_status.slot_last) |=> (r_state == S_IDLE))
        else $error("run did not end after final digit");
    a_conv_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && $past(r_state) == S_CONV) |-> ($past(r_step) == STEP_LAST))
        else $error("emission began before conversion finished");
`endif

endmodule

### src/lcd_decimal_field_writer_core.sv
// Top level: LCD decimal field writer, controller plus datapath.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------
//  input    | start in, busy out         | i_ddram_address, i_value, i_digit_count
//  result   | o_strobe out, no stall     | o_is_data, o_bus_byte, o_last
//
// One word in flight at a time. Accept, then digit extraction for all
// DIGIT_SLOTS slots (one reciprocal multiply per digit), cut short when count
// is 0. The command word is picked in the first extraction step and, like
// each data word, is on the outputs in the cycle after it is picked.
// The receiver cannot stall the result channel.
// Synchronous active-low reset returns the controller to idle.
module lcd_decimal_field_writer_core
    import lcdw_pkg::*;
#(
    parameter int DIGIT_SLOTS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [ADDR_W-1:0]  i_ddram_address,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [COUNT_W-1:0] i_digit_count,
    output logic               o_strobe,
    output logic               o_is_data,
    output logic [BYTE_W-1:0]  o_bus_byte,
    output logic               o_last
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    lcdw_ctrl #(
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_busy   (busy),
        .o_cmd    (w_cmd)
    );

    lcdw_datapath #(
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_ddram_address (i_ddram_address),
        .i_value         (i_value),
        .i_digit_count   (i_digit_count),
        .o_status        (w_status),
        .o_strobe        (o_strobe),
        .o_is_data       (o_is_data),
        .o_bus_byte      (o_bus_byte),
        .o_last          (o_last)
    );

endmodule

### tb/tb_lcd_decimal_field_writer_core.sv
// Testbench for the LCD decimal field writer: random and directed words, scoreboard check.
module tb_lcd_decimal_field_writer_core;
    import lcdw_pkg::*;

    localparam int SLOTS          = 8;
    localparam int RANDOM_ITEMS   = 410;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic              is_data;
        logic [BYTE_W-1:0] bus_byte;
        logic              last;
    } t_bus_write;

    class lcd_write_board;
        t_bus_write pending[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        // Expand one accepted word into its run of bus writes.
        function void note_item(logic [ADDR_W-1:0] addr, logic [VALUE_W-1:0] value,
                                logic [COUNT_W-1:0] count);
            logic [DIGIT_W-1:0] digits [SLOTS];
            int unsigned        rest;
            int unsigned        n;
            t_bus_write         w;
            rest = value;
            for (int pos = SLOTS - 1; pos >= 0; pos--) begin
                digits[pos] = DIGIT_W'(rest % 10);
                rest        = rest / 10;
            end
            n = (count > SLOTS) ? SLOTS : count;
            w.is_data  = 1'b0;
            w.bus_byte = addr;
            w.last     = (n == 0);
            pending.push_back(w);
            for (int i = 0; i < n; i++) begin
                w.is_data  = 1'b1;
                w.bus_byte = ASCII_ZERO + BYTE_W'(digits[SLOTS - n + i]);
                w.last     = (i + 1 == n);
                pending.push_back(w);
            end
        endfunction

        task check_write(t_bus_write got);
            t_bus_write want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected write rs=%0b byte=%02h last=%0b",
                                 got.is_data, got.bus_byte, got.last));
                return;
            end
            want = pending.pop_front();
            if (got.is_data !== want.is_data)
                report($sformatf("is_data got %0b want %0b", got.is_data, want.is_data));
            if (got.bus_byte !== want.bus_byte)
                report($sformatf("bus_byte got %02h want %02h", got.bus_byte, want.bus_byte));
            if (got.last !== want.last)
                report($sformatf("last got %0b want %0b", got.last, want.last));
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [ADDR_W-1:0]  i_ddram_address = '0;
    logic [VALUE_W-1:0] i_value = '0;
    logic [COUNT_W-1:0] i_digit_count = '0;
    logic               o_strobe;
    logic               o_is_data;
    logic [BYTE_W-1:0]  o_bus_byte;
    logic               o_last;

    lcd_write_board sb = new();
    int             idle_cycles = 0;
    bit             burst = 1'b0;

    lcd_decimal_field_writer_core #(
        .DIGIT_SLOTS(SLOTS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_ddram_address(i_ddram_address),
        .i_value(i_value),
        .i_digit_count(i_digit_count),
        .o_strobe(o_strobe),
        .o_is_data(o_is_data),
        .o_bus_byte(o_bus_byte),
        .o_last(o_last)
    );

    always #1 i_clk = ~i_clk;

    // Accepted words and writes, plus the watchdog.
    always @(posedge i_clk) begin
        idle_cycles++;
        if (i_rst_n) begin
            if (start && !busy) begin
                sb.note_item(i_ddram_address, i_value, i_digit_count);
                idle_cycles = 0;
            end
            if (o_strobe) begin
                sb.check_write('{o_is_data, o_bus_byte, o_last});
                idle_cycles = 0;
            end
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL lcd_decimal_field_writer_core");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 4);
        else
            return $urandom_range(5, 40);
    endfunction

    task automatic send_word(logic [ADDR_W-1:0] addr, logic [VALUE_W-1:0] value,
                             logic [COUNT_W-1:0] count);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_ddram_address <= addr;
        i_value         <= value;
        i_digit_count   <= count;
        do
            @(posedge i_clk);
        while (busy);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned p;
        case ($urandom_range(0, 3))
            0: return VALUE_W'($urandom);
            1: return VALUE_W'($urandom_range(0, 999));
            2: begin
                p = 1;
                repeat ($urandom_range(0, 4)) p = p * 10;
                return VALUE_W'(p - $urandom_range(0, 1));
            end
            default: return VALUE_W'($urandom_range(60000, 65535));
        endcase
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8)
            return COUNT_W'($urandom_range(1, 8));
        else if (r == 8)
            return '0;
        else
            return COUNT_W'($urandom_range(9, 15));
    endfunction

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every count, saturation, zero count, value and address extremes
        for (int c = 0; c < 16; c++)
            send_word(ADDR_W'(8'h80 + c), 16'd12345, COUNT_W'(c));
        send_word(8'h00, 16'd0, 4'd8);
        send_word(8'hff, 16'd65535, 4'd8);
        send_word(8'h55, 16'd65535, 4'd15);
        send_word(8'haa, 16'd10000, 4'd5);
        send_word(8'h0f, 16'd9999, 4'd4);
        send_word(8'hf0, 16'd0, 4'd0);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 50 == 0)
                burst = ($urandom_range(0, 2) == 0);
            send_word(ADDR_W'($urandom), pick_value(), pick_count());
        end

        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (SLOTS + 8) @(posedge i_clk);

        if (sb.errors == 0)
            $display("PASS lcd_decimal_field_writer_core");
        else
            $display("FAIL lcd_decimal_field_writer_core");
        $finish;
    end

endmodule
